[design/epc_pkg.sv]
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types and constants for the encoder position counter.
// ----------------------------------------------------------------------------
package epc_pkg;

	localparam int POS_WIDTH_DEF = 8;
	localparam int SETTLE_W      = 8;
	localparam int CFG_IDX_W     = 2;

	localparam int POS_MIN_RESET      = 0;
	localparam int POS_MAX_RESET      = 99;
	localparam int SETTLE_TICKS_RESET = 10;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_EDGE_A = 2'd1,
		CMD_EDGE_B = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_MIN      = 2'd0,
		REG_POS_MAX      = 2'd1,
		REG_SETTLE_TICKS = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_WAIT_HIGH = 3'd0,
		PH_SETTLE    = 3'd1,
		PH_SHOW      = 3'd2,
		PH_ARM       = 3'd3,
		PH_IDLE      = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [SETTLE_W-1:0] settle_cnt;
		logic                dir_up;
		logic                armed;
		logic                led;
	} ctl_state_t;

endpackage

[design/epc_if.sv]
// ----------------------------------------------------------------------------
// epc_if
// Valid/ready channels: encoder events in, position results out.
// ----------------------------------------------------------------------------
interface epc_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       chan_a;
	logic       chan_b;

	modport source (output valid, output cmd, output chan_a, output chan_b, input ready);
	modport sink   (input valid, input cmd, input chan_a, input chan_b, output ready);
endinterface

interface epc_res_if #(
	parameter int POS_WIDTH = epc_pkg::POS_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [POS_WIDTH-1:0] position;
	logic                 show_strobe;
	logic                 indicator;
	logic                 armed;

	modport source (output valid, output position, output show_strobe, output indicator,
		output armed, input ready);
	modport sink   (input valid, input position, input show_strobe, input indicator,
		input armed, output ready);
endinterface

[design/epc_step.sv]
// ----------------------------------------------------------------------------
// epc_step
// Next-state logic for one item: settle countdown, phase machine, position
// step with wrap, edge capture.
// ----------------------------------------------------------------------------
module epc_step #(
	parameter int POS_WIDTH = epc_pkg::POS_WIDTH_DEF
) (
	input  logic [1:0]                   cmd,
	input  logic                         chan_a,
	input  logic                         chan_b,
	input  epc_pkg::ctl_state_t          cur,
	input  logic [POS_WIDTH-1:0]         pos_cur,
	input  logic [POS_WIDTH-1:0]         pos_min,
	input  logic [POS_WIDTH-1:0]         pos_max,
	input  logic [epc_pkg::SETTLE_W-1:0] settle_ticks,
	output epc_pkg::ctl_state_t          nxt,
	output logic [POS_WIDTH-1:0]         pos_nxt,
	output logic                         strobe
);
	import epc_pkg::*;

	logic                 is_tick;
	logic                 edge_ok;
	logic                 both_high;
	logic                 cnt_done;
	logic [SETTLE_W-1:0]  tick_cnt;
	logic [POS_WIDTH-1:0] pos_up;
	logic [POS_WIDTH-1:0] pos_dn;
	phase_t               phase_nxt;

	assign is_tick   = (cmd == CMD_TICK);
	assign edge_ok   = ((cmd == CMD_EDGE_A) || (cmd == CMD_EDGE_B)) && cur.armed;
	assign both_high = chan_a && chan_b;
	assign tick_cnt  = (cur.settle_cnt != '0) ? cur.settle_cnt - 1'b1 : cur.settle_cnt;
	assign cnt_done  = (tick_cnt == '0);
	assign pos_up    = (pos_cur < pos_max) ? pos_cur + 1'b1 : pos_min;
	assign pos_dn    = (pos_cur > pos_min) ? pos_cur - 1'b1 : pos_max;

	always_comb begin
		phase_nxt = cur.phase;
		if (is_tick) begin
			unique case (cur.phase)
				PH_WAIT_HIGH: if (both_high) phase_nxt = PH_SETTLE;
				PH_SETTLE:    if (cnt_done) phase_nxt = PH_SHOW;
				PH_SHOW:      phase_nxt = PH_ARM;
				PH_ARM:       phase_nxt = PH_IDLE;
				PH_IDLE:      if (!cur.armed) phase_nxt = PH_WAIT_HIGH;
				default:      phase_nxt = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		nxt       = cur;
		nxt.phase = phase_nxt;
		pos_nxt   = pos_cur;
		strobe    = 1'b0;
		if (is_tick) begin
			nxt.settle_cnt = tick_cnt;
			unique case (cur.phase)
				PH_WAIT_HIGH: if (both_high) nxt.settle_cnt = settle_ticks;
				PH_SETTLE:    if (cnt_done) pos_nxt = cur.dir_up ? pos_up : pos_dn;
				PH_SHOW:      strobe = 1'b1;
				PH_ARM:       nxt.armed = 1'b1;
				default:      ;
			endcase
		end else if (edge_ok) begin
			nxt.dir_up = (cmd == CMD_EDGE_B);
			nxt.armed  = 1'b0;
			nxt.led    = ~cur.led;
		end
	end

endmodule

[design/encoder_position_counter_core.sv]
// ----------------------------------------------------------------------------
// encoder_position_counter_core
// Position counter driven by encoder edge events and timer ticks.
//
//   channel  dir  payload                                   handshake
//   evt      in   cmd, chan_a, chan_b                       valid/ready
//   res      out  position, show_strobe, indicator, armed   valid/ready
//   cfg      in   cfg_idx, cfg_wdata                        cfg_we, no wait
//
// One item per cycle unless res stalls. Path: input register, then one pass of
// next-state logic into the result register.
// Reset clears control state and loads register and state reset values.
// A stalled result holds the result register; the input register still
// takes one more item, then evt.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module encoder_position_counter_core #(
	parameter int POS_WIDTH = epc_pkg::POS_WIDTH_DEF,
	parameter int CFG_W     = (POS_WIDTH > epc_pkg::SETTLE_W) ? POS_WIDTH : epc_pkg::SETTLE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [epc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]              cfg_wdata,
	epc_evt_if.sink                       evt,
	epc_res_if.source                     res
);
	import epc_pkg::*;

	logic                 v_s1;
	logic [1:0]           cmd_s1;
	logic                 a_s1;
	logic                 b_s1;
	logic                 adv_s1;

	ctl_state_t           st_q;
	ctl_state_t           st_nxt;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] pos_nxt;
	logic                 strobe;

	logic [POS_WIDTH-1:0] pos_min_q;
	logic [POS_WIDTH-1:0] pos_max_q;
	logic [SETTLE_W-1:0]  settle_ticks_q;

	logic                 res_v_q;
	logic [POS_WIDTH-1:0] res_pos_q;
	logic                 res_strobe_q;
	logic                 res_led_q;
	logic                 res_armed_q;

	assign adv_s1    = v_s1 && (!res_v_q || res.ready);
	assign evt.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q      <= POS_WIDTH'(POS_MIN_RESET);
			pos_max_q      <= POS_WIDTH'(POS_MAX_RESET);
			settle_ticks_q <= SETTLE_W'(SETTLE_TICKS_RESET);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POS_MIN:      pos_min_q      <= cfg_wdata[POS_WIDTH-1:0];
				REG_POS_MAX:      pos_max_q      <= cfg_wdata[POS_WIDTH-1:0];
				REG_SETTLE_TICKS: settle_ticks_q <= cfg_wdata[SETTLE_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			cmd_s1 <= evt.cmd;
			a_s1   <= evt.chan_a;
			b_s1   <= evt.chan_b;
		end
	end

	epc_step #(
		.POS_WIDTH (POS_WIDTH)
	) u_step (
		.cmd          (cmd_s1),
		.chan_a       (a_s1),
		.chan_b       (b_s1),
		.cur          (st_q),
		.pos_cur      (pos_q),
		.pos_min      (pos_min_q),
		.pos_max      (pos_max_q),
		.settle_ticks (settle_ticks_q),
		.nxt          (st_nxt),
		.pos_nxt      (pos_nxt),
		.strobe       (strobe)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.settle_cnt <= SETTLE_W'(SETTLE_TICKS_RESET);
			st_q.dir_up     <= 1'b0;
			st_q.armed      <= 1'b1;
			st_q.led        <= 1'b0;
			pos_q           <= POS_WIDTH'(POS_MIN_RESET);
		end else if (adv_s1) begin
			st_q  <= st_nxt;
			pos_q <= pos_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (!res_v_q || res.ready) begin
			res_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_pos_q    <= pos_nxt;
			res_strobe_q <= strobe;
			res_led_q    <= st_nxt.led;
			res_armed_q  <= st_nxt.armed;
		end
	end

	assign res.valid       = res_v_q;
	assign res.position    = res_pos_q;
	assign res.show_strobe = res_strobe_q;
	assign res.indicator   = res_led_q;
	assign res.armed       = res_armed_q;

`ifndef SYNTHESIS
	a_strobe_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.show_strobe |-> !res.armed)
		else $error("display strobe while armed");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(pos_q))
		else $error("position moved without an item");

	a_s1_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |-> !evt.ready)
		else $error("input taken while stage one is stalled");
`endif

endmodule
